FILE: rtl/tpfd_pkg.sv
package tpfd_pkg;

  // Packet layout.
  localparam int SUBFRAMES       = 8;
  localparam int PALETTE_ENTRIES = 16;
  localparam int HEADER_SKIP     = 14;

  // Header mode words and the threshold that tells a mode from a palette word.
  localparam logic [15:0] MODE_THRESHOLD = 16'h1000;
  localparam logic [15:0] MODE_WIDE_A    = 16'h3038;
  localparam logic [15:0] MODE_WIDE_B    = 16'h4E4F;
  localparam logic [15:0] MODE_NARROW    = 16'h3135;

  // Tile grids selected by the mode word.
  localparam logic [5:0] WIDE_ACROSS   = 6'd32;
  localparam logic [3:0] WIDE_DOWN     = 4'd14;
  localparam logic [5:0] NARROW_ACROSS = 6'd15;
  localparam logic [3:0] NARROW_DOWN   = 4'd10;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WORD  = 3'd1,
    PH_SKIP  = 3'd2,
    PH_PAL   = 3'd3,
    PH_TILES = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAL = 2'd0,
    KIND_PIX = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  subframe;
    logic [3:0]  pal_index;
    logic [31:0] argb;
    logic [7:0]  pos_x;
    logic [6:0]  pos_y;
    logic [3:0]  pix_even;
    logic [3:0]  pix_odd;
    logic        last;
  } res_t;

  // 12-bit BGR to ARGB8888, every nibble doubled.
  function automatic logic [31:0] expand_color(logic [15:0] word);
    logic [3:0] b;
    logic [3:0] g;
    logic [3:0] r;
    b = word[11:8];
    g = word[7:4];
    r = word[3:0];
    return {ALPHA_OPAQUE, r, r, g, g, b, b};
  endfunction

endpackage

FILE: rtl/tpfd_parse.sv
module tpfd_parse import tpfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_in_i,
  input  logic       packet_start_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [4:0] HeaderSkipW = 5'(HEADER_SKIP);
  localparam logic [3:0] SubframesW  = 4'(SUBFRAMES);
  localparam logic [3:0] LastPalIdx  = 4'(PALETTE_ENTRIES - 1);

  phase_e     phase_q, phase_d;
  logic [5:0] tiles_across_q, tiles_across_d;
  logic [3:0] tiles_down_q, tiles_down_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic [4:0] byte_count_q, byte_count_d;
  logic [2:0] subframe_q, subframe_d;
  logic [4:0] tile_x_q, tile_x_d;
  logic [3:0] tile_y_q, tile_y_d;
  logic [2:0] row_q, row_d;
  logic [1:0] col_q, col_d;

  logic [15:0] word;
  logic [3:0]  pal_idx;

  assign word    = {held_byte_q, byte_in_i};
  assign pal_idx = byte_count_q[4:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      tiles_across_q <= WIDE_ACROSS;
      tiles_down_q   <= WIDE_DOWN;
      held_byte_q    <= '0;
      byte_count_q   <= '0;
      subframe_q     <= '0;
      tile_x_q       <= '0;
      tile_y_q       <= '0;
      row_q          <= '0;
      col_q          <= '0;
    end else begin
      phase_q        <= phase_d;
      tiles_across_q <= tiles_across_d;
      tiles_down_q   <= tiles_down_d;
      held_byte_q    <= held_byte_d;
      byte_count_q   <= byte_count_d;
      subframe_q     <= subframe_d;
      tile_x_q       <= tile_x_d;
      tile_y_q       <= tile_y_d;
      row_q          <= row_d;
      col_q          <= col_d;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    tiles_across_d = tiles_across_q;
    tiles_down_d   = tiles_down_q;
    held_byte_d    = held_byte_q;
    byte_count_d   = byte_count_q;
    subframe_d     = subframe_q;
    tile_x_d       = tile_x_q;
    tile_y_d       = tile_y_q;
    row_d          = row_q;
    col_d          = col_q;
    res_valid_o    = 1'b0;
    res_o          = '0;

    if (accept_i) begin
      if (packet_start_i) begin
        held_byte_d  = byte_in_i;
        subframe_d   = '0;
        byte_count_d = '0;
        tile_x_d     = '0;
        tile_y_d     = '0;
        row_d        = '0;
        col_d        = '0;
        phase_d      = PH_WORD;
      end else begin
        case (phase_q)
          PH_WORD: begin
            if (word > MODE_THRESHOLD) begin
              if (word == MODE_WIDE_A || word == MODE_WIDE_B ||
                  word == MODE_NARROW) begin
                if (word == MODE_NARROW) begin
                  tiles_across_d = NARROW_ACROSS;
                  tiles_down_d   = NARROW_DOWN;
                end else begin
                  tiles_across_d = WIDE_ACROSS;
                  tiles_down_d   = WIDE_DOWN;
                end
                byte_count_d = '0;
                phase_d      = (HeaderSkipW == 5'd0) ? PH_PAL : PH_SKIP;
              end else begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_ERR;
              end
            end else begin
              // No header: the first word is already palette entry zero.
              phase_d         = PH_PAL;
              byte_count_d    = 5'd2;
              res_valid_o     = 1'b1;
              res_o.kind      = KIND_PAL;
              res_o.subframe  = subframe_q;
              res_o.pal_index = '0;
              res_o.argb      = expand_color(word);
            end
          end
          PH_SKIP: begin
            byte_count_d = byte_count_q + 5'd1;
            if (byte_count_d >= HeaderSkipW) begin
              phase_d      = PH_PAL;
              byte_count_d = '0;
            end
          end
          PH_PAL: begin
            if (!byte_count_q[0]) begin
              held_byte_d  = byte_in_i;
              byte_count_d = byte_count_q + 5'd1;
            end else begin
              res_valid_o     = 1'b1;
              res_o.kind      = KIND_PAL;
              res_o.subframe  = subframe_q;
              res_o.pal_index = pal_idx;
              res_o.argb      = expand_color(word);
              if (pal_idx == LastPalIdx) begin
                phase_d      = PH_TILES;
                byte_count_d = '0;
                tile_x_d     = '0;
                tile_y_d     = '0;
                row_d        = '0;
                col_d        = '0;
              end else begin
                byte_count_d = byte_count_q + 5'd1;
              end
            end
          end
          PH_TILES: begin
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_PIX;
            res_o.subframe = subframe_q;
            res_o.pos_x    = {tile_x_q, col_q, 1'b0};
            res_o.pos_y    = {tile_y_q, row_q};
            res_o.pix_even = byte_in_i[7:4];
            res_o.pix_odd  = byte_in_i[3:0];
            col_d          = col_q + 2'd1;
            if (col_q == 2'd3) begin
              row_d = row_q + 3'd1;
              if (row_q == 3'd7) begin
                if (({1'b0, tile_x_q} + 6'd1) < tiles_across_q) begin
                  tile_x_d = tile_x_q + 5'd1;
                end else begin
                  tile_x_d = '0;
                  if (({1'b0, tile_y_q} + 5'd1) < {1'b0, tiles_down_q}) begin
                    tile_y_d = tile_y_q + 4'd1;
                  end else begin
                    tile_y_d = '0;
                    if (({1'b0, subframe_q} + 4'd1) >= SubframesW) begin
                      res_o.last = 1'b1;
                      subframe_d = '0;
                      phase_d    = PH_IDLE;
                    end else begin
                      subframe_d   = subframe_q + 3'd1;
                      phase_d      = PH_PAL;
                      byte_count_d = '0;
                    end
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_tiles_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TILES |-> byte_count_q == '0)
    else $error("byte count not clear during tile data");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> byte_count_q < HeaderSkipW)
    else $error("header skip ran past its length");

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> phase_q == PH_IDLE)
    else $error("final pixel pair did not end the packet");

endmodule

FILE: rtl/tpfd_skid.sv
module tpfd_skid import tpfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop         = main_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = res_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word held while the output word is empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && main_valid_q && !out_ready_i && !skid_valid_q |=> skid_valid_q)
    else $error("word pushed into a stalled output was lost");

endmodule

FILE: rtl/tile_palette_frame_decoder.sv
// Tile and palette frame decoder. Packet bytes arrive one byte per handshake,
// with packet_start_i marking the first byte of a packet; a start byte always
// aborts any packet in progress. An optional header (a first big-endian word
// above 0x1000 selects the tile grid, then a fixed number of bytes is
// skipped) is followed by sub-frames of 16 palette words and 4-bit-per-pixel
// 8x8 tiles. Each odd palette byte yields a palette word, each tile byte a
// pixel-pair word with raster coordinates, and an unsupported mode yields one
// error word after which the packet is ignored. Rate: one byte is accepted
// every clock cycle; each byte is decoded by combinational counter and nibble
// logic straight into a two-entry output buffer, so input only stalls once both
// buffer entries are full while the output is held off.
module tile_palette_frame_decoder import tpfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  subframe_o,
  output logic [3:0]  pal_index_o,
  output logic [31:0] argb_o,
  output logic [7:0]  pos_x_o,
  output logic [6:0]  pos_y_o,
  output logic [3:0]  pix_even_o,
  output logic [3:0]  pix_odd_o,
  output logic        last_o
);

  logic accept;
  logic res_valid;
  logic space;
  res_t res;
  res_t out_word;

  // A byte is taken whenever the output buffer still has a free entry, even
  // if that byte turns out to produce no word.
  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  tpfd_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .byte_in_i      (byte_in_i),
    .packet_start_i (packet_start_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  tpfd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_word)
  );

  assign kind_o      = out_word.kind;
  assign subframe_o  = out_word.subframe;
  assign pal_index_o = out_word.pal_index;
  assign argb_o      = out_word.argb;
  assign pos_x_o     = out_word.pos_x;
  assign pos_y_o     = out_word.pos_y;
  assign pix_even_o  = out_word.pix_even;
  assign pix_odd_o   = out_word.pix_odd;
  assign last_o      = out_word.last;

endmodule
